[src/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg: shared types, constants and compare functions
// Holds the table size, the word layouts that travel along the cell row and
// the rectangle tests that each cell applies to its own entry.
// ----------------------------------------------------------------------------
package rrt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W = 6;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_POINT  = 2'd2;
	localparam logic [1:0] MODE_ADJ    = 2'd3;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic signed [8:0] THR_ECHO = -9'sd1;
	localparam logic signed [8:0] THR_ZERO = 9'sd0;

	typedef struct packed {
		logic [7:0]  zone_id;
		logic [7:0]  zone_kind;
		logic [23:0] xl;
		logic [23:0] yl;
		logic [23:0] xh;
		logic [23:0] yh;
		logic [7:0]  turn;
	} rec_t;

	// query held still while its token walks the row
	typedef struct packed {
		logic              point;
		logic              echo;
		logic [7:0]        region;
		rec_t              rec;
		logic signed [8:0] thr;
	} qry_t;

	// token handed from cell to cell
	typedef struct packed {
		logic act;
		logic any;
		logic found;
		idx_t idx;
		rec_t rec;
	} tok_t;

	typedef struct packed {
		logic [1:0] status;
		idx_t       idx;
		rec_t       rec;
	} res_t;

	function automatic logic holds_point(input rec_t e, input rec_t q);
		holds_point = (q.xl >= e.xl) && (q.yl >= e.yl) && (q.xl <= e.xh) && (q.yl <= e.yh);
	endfunction

	function automatic logic adjoins(input rec_t e, input rec_t q);
		logic side_x;
		logic corner_x;
		logic side_y;
		logic corner_y;
		side_x   = ((q.xh == e.xl) || (q.xl == e.xh)) && (q.yl <= e.yh) && (q.yh >= e.yl);
		corner_x = ((q.xl == e.xl) || (q.xh == e.xh)) && ((q.yl == e.yh) || (q.yh == e.yl));
		side_y   = ((q.yh == e.yl) || (q.yl == e.yh)) && (q.xl <= e.xh) && (q.xh >= e.xl);
		corner_y = ((q.yl == e.yl) || (q.yh == e.yh)) && ((q.xl == e.xh) || (q.xh == e.xl));
		adjoins = side_x || corner_x || side_y || corner_y;
	endfunction

endpackage

[src/rrt_cell.sv]
// ----------------------------------------------------------------------------
// rrt_cell: one table slot in the search row
// Stores one entry, tests it against the broadcast query as the token passes
// and forwards the token, taking over the result on the first match.
// ----------------------------------------------------------------------------
module rrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  rrt_pkg::cnt_t slot,
	input  rrt_pkg::cnt_t count,
	input  logic          wr,
	input  logic [7:0]    wr_region,
	input  rrt_pkg::rec_t wr_rec,
	input  rrt_pkg::qry_t qry,
	input  rrt_pkg::tok_t tok_in,
	output rrt_pkg::tok_t tok_out
);

	logic [7:0]    region_q;
	rrt_pkg::rec_t entry_q;
	logic          act_q;
	logic          any_q;
	logic          found_q;
	rrt_pkg::idx_t idx_q;
	rrt_pkg::rec_t res_q;

	logic live;
	logic reg_hit;
	logic zone_ok;
	logic hit;

	always_comb begin
		live    = slot < count;
		reg_hit = live && (region_q == qry.region);
		zone_ok = $signed({1'b0, entry_q.zone_id}) > qry.thr;
		if (qry.point) begin
			hit = reg_hit && rrt_pkg::holds_point(entry_q, qry.rec);
		end else begin
			hit = reg_hit && !qry.echo && zone_ok && rrt_pkg::adjoins(entry_q, qry.rec);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			region_q <= wr_region;
			entry_q  <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.act;
		end
	end

	always_ff @(posedge clk) begin
		any_q   <= tok_in.any | reg_hit;
		found_q <= tok_in.found | hit;
		if (!tok_in.found && hit) begin
			idx_q <= rrt_pkg::idx_t'(slot);
			res_q <= entry_q;
		end else begin
			idx_q <= tok_in.idx;
			res_q <= tok_in.rec;
		end
	end

	assign tok_out = '{act: act_q, any: any_q, found: found_q, idx: idx_q, rec: res_q};

endmodule

[src/region_rectangle_table.sv]
// ----------------------------------------------------------------------------
// region_rectangle_table: region-tagged rectangle table with ordered search
// Clear, append, point lookup and adjacent lookup over a row of slot cells;
// lookups walk a token through the row in insertion order.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid, in_ready, mode .. zone_threshold  into block
//  output    out_valid, out_ready, status .. found_turn  out of block
//
//  clear and insert go from the wait state into the output register.
//  in lookups the token moves one cell per cycle
//  through the row of TABLE_ENTRIES slot cells.
//  one item is worked at a time; a new one is taken once the previous result
//  sits in the output register, even if that word is still stalled.
//  reset empties the table (entry count to zero); slot contents are not reset.
// ----------------------------------------------------------------------------
module region_rectangle_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [7:0]        region,
	input  logic [23:0]       x_low,
	input  logic [23:0]       y_low,
	input  logic [23:0]       x_high,
	input  logic [23:0]       y_high,
	input  logic [7:0]        zone_kind,
	input  logic [7:0]        zone_id,
	input  logic [7:0]        turn,
	input  logic signed [8:0] zone_threshold,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [5:0]        entry_index,
	output logic [7:0]        found_zone_id,
	output logic [7:0]        found_zone_kind,
	output logic [23:0]       found_x_low,
	output logic [23:0]       found_y_low,
	output logic [23:0]       found_x_high,
	output logic [23:0]       found_y_high,
	output logic [7:0]        found_turn
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]     state_q;
	rrt_pkg::cnt_t  count_q;
	logic           go_q;
	rrt_pkg::qry_t  qry_q;
	rrt_pkg::res_t  fin_q;
	rrt_pkg::res_t  out_q;
	logic           out_valid_q;

	rrt_pkg::tok_t  tok [0:rrt_pkg::TABLE_ENTRIES];
	rrt_pkg::rec_t  in_rec;
	rrt_pkg::res_t  empty_res;
	logic           accept;
	logic           full;
	logic           ins_go;
	logic           out_free;
	rrt_pkg::tok_t  tok_end;
	rrt_pkg::res_t  scan_res;

	assign in_rec = '{zone_id: zone_id, zone_kind: zone_kind, xl: x_low, yl: y_low,
		xh: x_high, yh: y_high, turn: turn};
	assign empty_res = '{status: rrt_pkg::STAT_DONE, idx: '0, rec: '0};

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = count_q >= rrt_pkg::cnt_t'(rrt_pkg::TABLE_ENTRIES);
	assign ins_go   = accept && (mode == rrt_pkg::MODE_INSERT) && !full;
	assign out_free = !out_valid_q || out_ready;
	assign tok_end  = tok[rrt_pkg::TABLE_ENTRIES];

	assign tok[0] = '{act: go_q, any: 1'b0, found: 1'b0, idx: '0, rec: '0};

	genvar gi;
	generate
		for (gi = 0; gi < rrt_pkg::TABLE_ENTRIES; gi++) begin : g_cell
			rrt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.slot      (rrt_pkg::cnt_t'(gi)),
				.count     (count_q),
				.wr        (ins_go && (count_q == rrt_pkg::cnt_t'(gi))),
				.wr_region (region),
				.wr_rec    (in_rec),
				.qry       (qry_q),
				.tok_in    (tok[gi]),
				.tok_out   (tok[gi+1])
			);
		end
	endgenerate

	// echo mode answers from the query itself once any same-region entry exists
	always_comb begin
		scan_res = empty_res;
		scan_res.status = rrt_pkg::STAT_MISS;
		if (qry_q.echo) begin
			if (tok_end.any) begin
				scan_res = '{status: rrt_pkg::STAT_DONE, idx: '0, rec: qry_q.rec};
			end
		end else if (tok_end.found) begin
			scan_res = '{status: rrt_pkg::STAT_DONE, idx: tok_end.idx, rec: tok_end.rec};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							rrt_pkg::MODE_CLEAR: begin
								count_q <= '0;
								state_q <= S_WAIT;
							end
							rrt_pkg::MODE_INSERT: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_WAIT;
							end
							default: begin
								go_q    <= 1'b1;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (tok_end.act) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q.point  <= (mode == rrt_pkg::MODE_POINT);
			qry_q.echo   <= (mode == rrt_pkg::MODE_ADJ) && (zone_threshold == rrt_pkg::THR_ECHO);
			qry_q.region <= region;
			qry_q.rec    <= in_rec;
			qry_q.thr    <= (zone_threshold == rrt_pkg::THR_ZERO) ? rrt_pkg::THR_ECHO
				: zone_threshold;
			case (mode)
				rrt_pkg::MODE_CLEAR: begin
					fin_q <= empty_res;
				end
				rrt_pkg::MODE_INSERT: begin
					if (full) begin
						fin_q <= '{status: rrt_pkg::STAT_FULL, idx: '0, rec: '0};
					end else begin
						fin_q <= '{status: rrt_pkg::STAT_DONE, idx: rrt_pkg::idx_t'(count_q),
							rec: in_rec};
					end
				end
				default: begin
					fin_q <= fin_q;
				end
			endcase
		end else if (state_q == S_SCAN && tok_end.act) begin
			fin_q <= scan_res;
		end
		if (state_q == S_WAIT && out_free) begin
			out_q <= fin_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign entry_index     = out_q.idx;
	assign found_zone_id   = out_q.rec.zone_id;
	assign found_zone_kind = out_q.rec.zone_kind;
	assign found_x_low     = out_q.rec.xl;
	assign found_y_low     = out_q.rec.yl;
	assign found_x_high    = out_q.rec.xh;
	assign found_y_high    = out_q.rec.yh;
	assign found_turn      = out_q.rec.turn;

endmodule
